// File: src/prbe_pkg.sv
// Shared types and codes for the palette range blend editor.
`timescale 1ns / 1ps
package prbe_pkg;

  // Command codes carried in the cmd field
  typedef enum logic [2:0] {
    CMD_WRITE = 3'd0,
    CMD_READ  = 3'd1,
    CMD_ADD   = 3'd2,
    CMD_SUB   = 3'd3,
    CMD_MOD   = 3'd4
  } cmd_t;

  // Per-channel blend selection for the shared unit
  typedef enum logic [1:0] {
    BOP_SAT_ADD   = 2'd0,
    BOP_CLAMP_SUB = 2'd1,
    BOP_NORM_MUL  = 2'd2
  } blend_op_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE = 3'd0,
    ST_READ = 3'd1,
    ST_CH0  = 3'd2,
    ST_CH1  = 3'd3,
    ST_CH2  = 3'd4
  } state_t;

  // Width of run counters: idx + run_length reaches 510
  localparam int unsigned CNT_W = 10;

  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] entry_index;
    logic [7:0] run_length;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } in_item_t;

  typedef struct packed {
    logic       status;
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
  } out_item_t;

endpackage

// File: src/prbe_blend_unit.sv
// Shared one-channel blend unit: saturating add, clamped subtract, normalized product.
`timescale 1ns / 1ps
module prbe_blend_unit
  import prbe_pkg::*;
(
  input  blend_op_t  op,
  input  logic [7:0] a,
  input  logic [7:0] b,
  output logic [7:0] y
);

  logic [8:0]  sum;
  logic [15:0] prod;
  logic [16:0] scaled;

  always_comb begin
    sum    = {1'b0, a} + {1'b0, b};
    prod   = 16'(a) * 16'(b);
    // floor(prod / 255), exact for 16-bit prod
    scaled = 17'(prod) + 17'(prod[15:8]) + 17'd1;
    case (op)
      BOP_SAT_ADD:   y = sum[8] ? 8'hFF : sum[7:0];
      BOP_CLAMP_SUB: y = (a > b) ? (a - b) : 8'd0;
      default:       y = scaled[15:8];
    endcase
  end

endmodule

// File: src/palette_range_blend_editor.sv
// Top level: palette store with write, read and range blend commands.
`timescale 1ns / 1ps
// Order: write, error, zero-length run, unknown command: result the cycle after accept;
//   a read passes ST_READ; a run visits ST_CH0/1/2 per entry, one state per channel.
// Throughput: one item at a time; busy stays high while a read or run is in flight.
// Reset (rst_n, synchronous): idle, no result pending, 256 entries in use; store
//   contents undefined until written. The receiver cannot stall results.
module palette_range_blend_editor
  import prbe_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = 256
) (
  input  logic      clk,
  input  logic      rst_n,
  // command channel
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  // result channel
  output logic      out_valid,
  output out_item_t out_item,
  // configuration: entries in use
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic [8:0] cfg_data
);

  localparam int unsigned AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

  // palette memory, one 24-bit RGB word per entry
  logic [23:0] mem [MAX_ENTRIES];

  state_t          state_r, state_nxt;
  logic [8:0]      pal_entries_r;
  logic [CNT_W-1:0] cur_r, cur_nxt;
  logic [CNT_W-1:0] end_r, end_nxt;
  logic [23:0]     opnd_r, opnd_nxt;
  blend_op_t       bop_r, bop_nxt;
  logic [7:0]      res0_r, res0_nxt;
  logic [7:0]      res1_r, res1_nxt;
  logic [23:0]     rd_r;
  logic            out_valid_r, out_valid_nxt;
  out_item_t       out_item_r, out_item_nxt;

  // memory port controls
  logic            rd_en;
  logic [AW-1:0]   rd_addr;
  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  logic [23:0]     wr_data;

  // shared blend unit
  logic [7:0]      bl_a, bl_b, bl_y;

  logic            accept;
  logic [CNT_W-1:0] used;
  logic [CNT_W-1:0] idx_w;
  logic [CNT_W-1:0] run_end;
  logic [CNT_W-1:0] cur_inc;

  prbe_blend_unit u_blend (
    .op (bop_r),
    .a  (bl_a),
    .b  (bl_b),
    .y  (bl_y)
  );

  assign busy      = (state_r != ST_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // entries in use, capped at the store depth
  assign used    = (32'(pal_entries_r) > MAX_ENTRIES) ? CNT_W'(MAX_ENTRIES)
                                                      : CNT_W'(pal_entries_r);
  assign idx_w   = CNT_W'(in_item.entry_index);
  assign cur_inc = cur_r + CNT_W'(1);

  // clip the exclusive run end to the number of entries in use
  always_comb begin
    run_end = idx_w + CNT_W'(in_item.run_length);
    if (run_end > used) begin
      run_end = used;
    end
  end

  // channel select into the blend unit
  always_comb begin
    unique case (state_r)
      ST_CH0: begin
        bl_a = rd_r[23:16];
        bl_b = opnd_r[23:16];
      end
      ST_CH1: begin
        bl_a = rd_r[15:8];
        bl_b = opnd_r[15:8];
      end
      default: begin
        bl_a = rd_r[7:0];
        bl_b = opnd_r[7:0];
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    cur_nxt       = cur_r;
    end_nxt       = end_r;
    opnd_nxt      = opnd_r;
    bop_nxt       = bop_r;
    res0_nxt      = res0_r;
    res1_nxt      = res1_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = '0;
    rd_en         = 1'b0;
    rd_addr       = AW'(in_item.entry_index);
    wr_en         = 1'b0;
    wr_addr       = AW'(in_item.entry_index);
    wr_data       = {in_item.red_in, in_item.green_in, in_item.blue_in};

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          opnd_nxt = {in_item.red_in, in_item.green_in, in_item.blue_in};
          cur_nxt  = idx_w;
          end_nxt  = run_end;
          priority if (in_item.cmd == CMD_WRITE) begin
            // unchecked against entries in use, only against the store depth
            wr_en         = (32'(in_item.entry_index) < MAX_ENTRIES);
            out_valid_nxt = 1'b1;
          end else if (in_item.cmd == CMD_READ) begin
            if (idx_w >= used) begin
              out_valid_nxt       = 1'b1;
              out_item_nxt.status = 1'b1;
            end else begin
              rd_en     = 1'b1;
              state_nxt = ST_READ;
            end
          end else if (in_item.cmd == CMD_ADD || in_item.cmd == CMD_SUB ||
                       in_item.cmd == CMD_MOD) begin
            priority if (in_item.cmd == CMD_ADD) begin
              bop_nxt = BOP_SAT_ADD;
            end else if (in_item.cmd == CMD_SUB) begin
              bop_nxt = BOP_CLAMP_SUB;
            end else begin
              bop_nxt = BOP_NORM_MUL;
            end
            if (idx_w >= used) begin
              out_valid_nxt       = 1'b1;
              out_item_nxt.status = 1'b1;
            end else if (in_item.run_length == 8'd0) begin
              out_valid_nxt = 1'b1;
            end else begin
              rd_en     = 1'b1;
              state_nxt = ST_CH0;
            end
          end else begin
            // unknown command: plain ok
            out_valid_nxt = 1'b1;
          end
        end
      end

      ST_READ: begin
        out_valid_nxt          = 1'b1;
        out_item_nxt.red_out   = rd_r[23:16];
        out_item_nxt.green_out = rd_r[15:8];
        out_item_nxt.blue_out  = rd_r[7:0];
        state_nxt              = ST_IDLE;
      end

      ST_CH0: begin
        res0_nxt  = bl_y;
        state_nxt = ST_CH1;
      end

      ST_CH1: begin
        res1_nxt  = bl_y;
        state_nxt = ST_CH2;
      end

      ST_CH2: begin
        // write back this entry and fetch the next one in the same cycle
        wr_en   = 1'b1;
        wr_addr = AW'(cur_r);
        wr_data = {res0_r, res1_r, bl_y};
        if (cur_inc == end_r) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end else begin
          cur_nxt   = cur_inc;
          rd_en     = 1'b1;
          rd_addr   = AW'(cur_inc);
          state_nxt = ST_CH0;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // palette memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_r <= mem[rd_addr];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      out_valid_r   <= 1'b0;
      pal_entries_r <= 9'd256;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        pal_entries_r <= cfg_data;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    end_r      <= end_nxt;
    opnd_r     <= opnd_nxt;
    bop_r      <= bop_nxt;
    res0_r     <= res0_nxt;
    res1_r     <= res1_nxt;
    out_item_r <= out_item_nxt;
  end

endmodule
